>>> sv/rgbc_pkg.sv
// Shared constants, types and pixel math for the RGBA-over-RGB565 compositor.
// No dependencies; used by every module of the block.
package rgbc_pkg;

  // Display and frame store geometry
  localparam int DISPLAY_WIDTH  = 256;
  localparam int DISPLAY_HEIGHT = 256;
  localparam int ADDR_W         = 16;   // frame store depth 2**ADDR_W
  localparam int PIX_W          = 16;   // RGB565

  // Field widths
  localparam int COORD_W    = 17;
  localparam int OFFSET_W   = 16;
  localparam int COUNT_W    = 12;
  localparam int WIDTH_W    = 13;
  localparam int MAX_WIDTH  = 4096;
  localparam int CHAN_W     = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd2;

  // Stream widths
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 56;
  localparam int M_TUSER_W = 2;

  // One classified pixel, passed from front to back
  typedef struct packed {
    logic [COORD_W-1:0] tx;
    logic [COORD_W-1:0] ty;
    logic [ADDR_W-1:0]  addr;
    logic               clipped;
    logic               any_clipped;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  alpha;
  } pix_op_t;

  function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [CHAN_W-1:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // (c*a + old*(255-a)) >> 8
  function automatic logic [CHAN_W-1:0] mix(input logic [CHAN_W-1:0] c,
                                            input logic [CHAN_W-1:0] old,
                                            input logic [CHAN_W-1:0] a);
    logic [16:0] s;
    s = {9'd0, c} * {9'd0, a} + {9'd0, old} * {9'd0, 8'hFF - a};
    return s[15:8];
  endfunction

  function automatic logic [PIX_W-1:0] blend565(input logic [PIX_W-1:0]  old,
                                                input logic [CHAN_W-1:0] r,
                                                input logic [CHAN_W-1:0] g,
                                                input logic [CHAN_W-1:0] b,
                                                input logic [CHAN_W-1:0] a);
    logic [CHAN_W-1:0] mr;
    logic [CHAN_W-1:0] mg;
    logic [CHAN_W-1:0] mb;
    mr = mix(r, widen5(old[15:11]), a);
    mg = mix(g, widen6(old[10:5]), a);
    mb = mix(b, widen5(old[4:0]), a);
    if (a == 8'h00) begin
      return old;
    end else if (a == 8'hFF) begin
      return {r[7:3], g[7:2], b[7:3]};
    end else begin
      return {mr[7:3], mg[7:2], mb[7:3]};
    end
  endfunction

endpackage

>>> sv/rgba_over_rgb565_compositor_unit.sv
// Top level of the RGBA8888-over-RGB565 compositor: stream ports, front, queue, back.
// Depends on rgbc_pkg, rgbc_front, rgbc_queue, rgbc_back.
//
// Composites a raster-order stream of RGBA8888 pixels into a 256 x 256 RGB565
// frame store at (offset_x + column, offset_y + row). Alpha 0 keeps the stored
// pixel, alpha 255 replaces it, anything else blends against the stored pixel
// widened to 8 bits per channel. Every input transaction yields exactly one
// output transaction carrying the target position, the color now stored
// there (zero when clipped), a per-pixel clip flag and a sticky per-image
// clip flag; start_of_image on tuser restarts the raster and the sticky flag.
// Throughput is one pixel per clock while the output is not stalled: the front
// classifies a pixel in the cycle it is accepted, a two-entry queue decouples
// it from the back, and the back reads the store into a registered read and then
// blends and writes it from its blend stage, with a bypass of the last write so
// consecutive hits on the same address are exact. From input to output a pixel
// passes the queue, the blend stage and the output register. After reset the
// block clears all 65536 entries of the frame store, one entry a cycle;
// s_tready stays low until then, while configuration writes are taken at any
// time. Change configuration only while no pixel is in flight.
module rgba_over_rgb565_compositor_unit (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_wen,
  input  logic [rgbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgbc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // pixel input
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rgbc_pkg::S_TDATA_W-1:0]    s_tdata,   // red, green, blue, alpha
  input  logic [rgbc_pkg::S_TUSER_W-1:0]    s_tuser,   // start_of_image
  // result output
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rgbc_pkg::M_TDATA_W-1:0]    m_tdata,   // target_x, target_y, pixel_color, pad
  output logic [rgbc_pkg::M_TUSER_W-1:0]    m_tuser    // pixel_clipped, any_clipped
);

  logic                            q_full;
  logic                            q_empty;
  logic                            push;
  logic                            pop;
  logic                            store_ready;
  rgbc_pkg::pix_op_t               push_op;
  rgbc_pkg::pix_op_t               head_op;

  logic [rgbc_pkg::COORD_W-1:0]    target_x;
  logic [rgbc_pkg::COORD_W-1:0]    target_y;
  logic [rgbc_pkg::PIX_W-1:0]      pixel_color;
  logic                            pixel_clipped;
  logic                            any_clipped;

  rgbc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_sof      (s_tuser[0]),
    .in_red      (s_tdata[7:0]),
    .in_green    (s_tdata[15:8]),
    .in_blue     (s_tdata[23:16]),
    .in_alpha    (s_tdata[31:24]),
    .q_full      (q_full),
    .store_ready (store_ready),
    .push        (push),
    .push_op     (push_op)
  );

  rgbc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .empty   (q_empty),
    .head_op (head_op)
  );

  rgbc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_op            (head_op),
    .pop             (pop),
    .store_ready     (store_ready),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_tx          (target_x),
    .out_ty          (target_y),
    .out_color       (pixel_color),
    .out_clipped     (pixel_clipped),
    .out_any_clipped (any_clipped)
  );

  // 17 + 17 + 16 = 50 bits, zero padded to 56
  assign m_tdata = {6'd0, pixel_color, target_y, target_x};
  assign m_tuser = {any_clipped, pixel_clipped};

endmodule

>>> sv/rgbc_front.sv
// Front end: config registers, column/row tracking, target and clip classification.
// Depends on rgbc_pkg.
module rgbc_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [rgbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_sof,
  input  logic [rgbc_pkg::CHAN_W-1:0]      in_red,
  input  logic [rgbc_pkg::CHAN_W-1:0]      in_green,
  input  logic [rgbc_pkg::CHAN_W-1:0]      in_blue,
  input  logic [rgbc_pkg::CHAN_W-1:0]      in_alpha,
  input  logic                             q_full,
  input  logic                             store_ready,
  output logic                             push,
  output rgbc_pkg::pix_op_t                push_op
);

  logic [rgbc_pkg::OFFSET_W-1:0] offset_x;
  logic [rgbc_pkg::OFFSET_W-1:0] offset_y;
  logic [rgbc_pkg::WIDTH_W-1:0]  image_width;
  logic [rgbc_pkg::COUNT_W-1:0]  column_count;
  logic [rgbc_pkg::COUNT_W-1:0]  row_count;
  logic                          clip_seen;

  logic [rgbc_pkg::COUNT_W-1:0]  col_cur;
  logic [rgbc_pkg::COUNT_W-1:0]  row_cur;
  logic                          seen_cur;
  logic [rgbc_pkg::COORD_W-1:0]  tx;
  logic [rgbc_pkg::COORD_W-1:0]  ty;
  logic                          clipped;
  logic [rgbc_pkg::ADDR_W-1:0]   row_base;
  logic [rgbc_pkg::WIDTH_W-1:0]  width_eff;
  logic [rgbc_pkg::WIDTH_W-1:0]  col_inc;
  logic                          row_end;
  logic [rgbc_pkg::COUNT_W-1:0]  column_count_next;
  logic [rgbc_pkg::COUNT_W-1:0]  row_count_next;

  assign in_ready = !q_full && store_ready;
  assign push     = in_valid && in_ready;

  // start of image restarts the raster before this pixel
  assign col_cur  = in_sof ? '0 : column_count;
  assign row_cur  = in_sof ? '0 : row_count;
  assign seen_cur = in_sof ? 1'b0 : clip_seen;

  assign tx = {1'b0, offset_x} + {{(rgbc_pkg::COORD_W - rgbc_pkg::COUNT_W){1'b0}}, col_cur};
  assign ty = {1'b0, offset_y} + {{(rgbc_pkg::COORD_W - rgbc_pkg::COUNT_W){1'b0}}, row_cur};

  assign clipped = (tx >= rgbc_pkg::COORD_W'(rgbc_pkg::DISPLAY_WIDTH)) ||
                   (ty >= rgbc_pkg::COORD_W'(rgbc_pkg::DISPLAY_HEIGHT));

  assign row_base = rgbc_pkg::ADDR_W'(ty * rgbc_pkg::COORD_W'(rgbc_pkg::DISPLAY_WIDTH));

  always_comb begin
    push_op             = '0;
    push_op.tx          = tx;
    push_op.ty          = ty;
    push_op.addr        = row_base + rgbc_pkg::ADDR_W'(tx);
    push_op.clipped     = clipped;
    push_op.any_clipped = seen_cur | clipped;
    push_op.red         = in_red;
    push_op.green       = in_green;
    push_op.blue        = in_blue;
    push_op.alpha       = in_alpha;
  end

  // zero or oversized width behaves as the maximum
  assign width_eff = ((image_width == '0) ||
                      (image_width > rgbc_pkg::WIDTH_W'(rgbc_pkg::MAX_WIDTH))) ?
                     rgbc_pkg::WIDTH_W'(rgbc_pkg::MAX_WIDTH) : image_width;
  assign col_inc   = {1'b0, col_cur} + rgbc_pkg::WIDTH_W'(1);
  assign row_end   = col_inc >= width_eff;

  assign column_count_next = row_end ? '0 : col_inc[rgbc_pkg::COUNT_W-1:0];
  assign row_count_next    = row_end ? row_cur + rgbc_pkg::COUNT_W'(1) : row_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x     <= '0;
      offset_y     <= '0;
      image_width  <= rgbc_pkg::WIDTH_W'(1);
      column_count <= '0;
      row_count    <= '0;
      clip_seen    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          rgbc_pkg::REG_OFFSET_X:    offset_x    <= cfg_data;
          rgbc_pkg::REG_OFFSET_Y:    offset_y    <= cfg_data;
          rgbc_pkg::REG_IMAGE_WIDTH: image_width <= cfg_data[rgbc_pkg::WIDTH_W-1:0];
          default: ;
        endcase
      end
      if (push) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        clip_seen    <= seen_cur | clipped;
      end
    end
  end

endmodule

>>> sv/rgbc_queue.sv
// Two-entry FIFO of classified pixels between front and back.
// Depends on rgbc_pkg.
module rgbc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rgbc_pkg::pix_op_t push_op,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output rgbc_pkg::pix_op_t head_op
);

  rgbc_pkg::pix_op_t entries [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign head_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

>>> sv/rgbc_back.sv
// Back end: frame store with clearing pass, read-modify-write blend, output register.
// Depends on rgbc_pkg.
module rgbc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  rgbc_pkg::pix_op_t             q_op,
  output logic                          pop,
  output logic                          store_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rgbc_pkg::COORD_W-1:0]  out_tx,
  output logic [rgbc_pkg::COORD_W-1:0]  out_ty,
  output logic [rgbc_pkg::PIX_W-1:0]    out_color,
  output logic                          out_clipped,
  output logic                          out_any_clipped
);

  localparam int STORE_DEPTH = 2 ** rgbc_pkg::ADDR_W;

  logic [rgbc_pkg::PIX_W-1:0]  frame_store [STORE_DEPTH];

  logic                        clearing;
  logic [rgbc_pkg::ADDR_W-1:0] clr_addr;

  // blend stage
  logic                        b_valid;
  rgbc_pkg::pix_op_t           b_op;
  logic [rgbc_pkg::PIX_W-1:0]  rd_data;
  logic                        b_adv;
  logic [rgbc_pkg::PIX_W-1:0]  old_pix;
  logic [rgbc_pkg::PIX_W-1:0]  color;

  // most recent store write, covers a read issued on the same edge
  logic                        lw_valid;
  logic [rgbc_pkg::ADDR_W-1:0] lw_addr;
  logic [rgbc_pkg::PIX_W-1:0]  lw_color;

  assign store_ready = !clearing;
  assign b_adv       = b_valid && (!out_valid || out_ready);
  assign pop         = !q_empty && !clearing && (!b_valid || b_adv);

  assign old_pix = (lw_valid && (lw_addr == b_op.addr)) ? lw_color : rd_data;
  assign color   = b_op.clipped ? '0 :
                   rgbc_pkg::blend565(old_pix, b_op.red, b_op.green, b_op.blue, b_op.alpha);

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (clearing) begin
      frame_store[clr_addr] <= '0;
    end else if (b_adv && !b_op.clipped) begin
      frame_store[b_op.addr] <= color;
    end
    if (pop) begin
      rd_data <= frame_store[q_op.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_op <= q_op;
    end
    if (b_adv && !b_op.clipped) begin
      lw_addr  <= b_op.addr;
      lw_color <= color;
    end
    if (b_adv) begin
      out_tx          <= b_op.tx;
      out_ty          <= b_op.ty;
      out_color       <= color;
      out_clipped     <= b_op.clipped;
      out_any_clipped <= b_op.any_clipped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      b_valid   <= 1'b0;
      lw_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + rgbc_pkg::ADDR_W'(1);
        if (clr_addr == '1) begin
          clearing <= 1'b0;
        end
      end
      if (pop) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_adv && !b_op.clipped) begin
        lw_valid <= 1'b1;
      end
      if (b_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> tb/tb_rgba_over_rgb565_compositor_unit.sv
// Self-checking testbench for rgba_over_rgb565_compositor_unit.
// Depends on rgbc_pkg and the compositor RTL; a scoreboard class predicts every output transaction.
module tb_rgba_over_rgb565_compositor_unit;
  import rgbc_pkg::*;

  // Watchdog. A correct run needs the full store clear plus all images sent at
  // the slowest mix of sender gaps and receiver stalls.
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned RANDOM_ITEMS = 800;

  // One expected output transaction
  typedef struct {
    bit [COORD_W-1:0] tx;
    bit [COORD_W-1:0] ty;
    bit [PIX_W-1:0]   color;
    bit               clipped;
    bit               any_clipped;
  } pixel_result_t;

  // Scoreboard: a private copy of the frame store, raster counters and
  // registers. Every accepted pixel is composited here and its outcome is queued.
  class canvas_tracker;
    bit [PIX_W-1:0]    canvas [2**ADDR_W];
    bit [OFFSET_W-1:0] off_x;
    bit [OFFSET_W-1:0] off_y;
    bit [WIDTH_W-1:0]  img_w = 1;
    bit [COUNT_W-1:0]  col;
    bit [COUNT_W-1:0]  row;
    bit                sticky;
    pixel_result_t     expected_pixels[$];
    int unsigned       faults;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_OFFSET_X:    off_x = val;
        REG_OFFSET_Y:    off_y = val;
        REG_IMAGE_WIDTH: img_w = val[WIDTH_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [CHAN_W-1:0] weigh(int unsigned c, int unsigned o, int unsigned a);
      int unsigned s;
      s = c * a + o * (255 - a);
      return s[15:8];
    endfunction

    // Stored 565 pixel widened by bit replication, then mixed channel by channel
    function bit [PIX_W-1:0] composite(bit [PIX_W-1:0] old, bit [7:0] r, bit [7:0] g,
                                       bit [7:0] b, bit [7:0] a);
      bit [7:0] mr;
      bit [7:0] mg;
      bit [7:0] mb;
      if (a == 8'h00) return old;
      if (a == 8'hFF) return {r[7:3], g[7:2], b[7:3]};
      mr = weigh(r, {old[15:11], old[15:13]}, a);
      mg = weigh(g, {old[10:5], old[10:9]}, a);
      mb = weigh(b, {old[4:0], old[4:2]}, a);
      return {mr[7:3], mg[7:2], mb[7:3]};
    endfunction

    function void absorb_pixel(bit sof, bit [7:0] r, bit [7:0] g, bit [7:0] b, bit [7:0] a);
      pixel_result_t res;
      int unsigned   lin;
      int unsigned   span;
      if (sof) begin
        col = '0;
        row = '0;
        sticky = 1'b0;
      end
      res.tx = COORD_W'(off_x) + COORD_W'(col);
      res.ty = COORD_W'(off_y) + COORD_W'(row);
      res.clipped = (res.tx >= DISPLAY_WIDTH) || (res.ty >= DISPLAY_HEIGHT);
      res.color = '0;
      if (res.clipped) begin
        sticky = 1'b1;
      end else begin
        lin = res.ty * DISPLAY_WIDTH + res.tx;
        res.color = composite(canvas[lin[ADDR_W-1:0]], r, g, b, a);
        canvas[lin[ADDR_W-1:0]] = res.color;
      end
      res.any_clipped = sticky;
      // width 0 or anything past the maximum behaves as the maximum
      span = (img_w == 0 || img_w > MAX_WIDTH) ? MAX_WIDTH : int'(img_w);
      if (int'(col) + 1 >= span) begin
        col = '0;
        row = row + COUNT_W'(1);
      end else begin
        col = col + COUNT_W'(1);
      end
      expected_pixels.push_back(res);
    endfunction

    function void check_pixel(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
      pixel_result_t want;
      if (expected_pixels.size() == 0) begin
        $error("result transaction with nothing pending: tdata %h tuser %b", data, user);
        faults++;
        return;
      end
      want = expected_pixels.pop_front();
      if (data[COORD_W-1:0] !== want.tx) begin
        $error("target_x: expected %0d, got %0d", want.tx, data[COORD_W-1:0]);
        faults++;
      end
      if (data[2*COORD_W-1:COORD_W] !== want.ty) begin
        $error("target_y: expected %0d, got %0d", want.ty, data[2*COORD_W-1:COORD_W]);
        faults++;
      end
      if (data[2*COORD_W+PIX_W-1:2*COORD_W] !== want.color) begin
        $error("pixel_color: expected %h, got %h", want.color,
               data[2*COORD_W+PIX_W-1:2*COORD_W]);
        faults++;
      end
      if (user[0] !== want.clipped) begin
        $error("pixel_clipped: expected %b, got %b", want.clipped, user[0]);
        faults++;
      end
      if (user[1] !== want.any_clipped) begin
        $error("any_clipped: expected %b, got %b", want.any_clipped, user[1]);
        faults++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_OFFSET_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;     // red, green, blue, alpha
  logic [S_TUSER_W-1:0]  s_tuser = '0;     // start_of_image
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;          // target_x, target_y, pixel_color, pad
  logic [M_TUSER_W-1:0]  m_tuser;          // pixel_clipped, any_clipped

  canvas_tracker ledger = new();
  int unsigned   cycle_count = 0;
  int unsigned   burst_left = 1;
  int unsigned   random_total = 0;
  int unsigned   stall_left = 0;
  int unsigned   stall_mode = 0;

  rgba_over_rgb565_compositor_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver backpressure: a mode is held for a window, then redrawn.
  // Modes: always ready, coin flip, mostly stalled, strict alternation.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ~m_tready;
    endcase
  end

  // Both handshakes are sampled at the edge with pre-edge values; the input
  // side goes first so an expectation always exists before its result.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        ledger.absorb_pixel(s_tuser[0], s_tdata[7:0], s_tdata[15:8], s_tdata[23:16],
                            s_tdata[31:24]);
      if (m_tvalid && m_tready)
        ledger.check_pixel(m_tdata, m_tuser);
    end
  end

  // Holds the register write for one edge; the caller lowers cfg_wen.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    ledger.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] ox, input logic [15:0] oy,
                              input logic [15:0] w);
    put_reg(REG_OFFSET_X, ox);
    put_reg(REG_OFFSET_Y, oy);
    put_reg(REG_IMAGE_WIDTH, w);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  // One pixel transaction. The sender runs in bursts; at the end of a burst
  // tvalid drops for a random gap and a new burst length is drawn, now and
  // then a long one so that stretches without idling occur.
  task automatic send_pixel(input bit sof, input bit [7:0] r, input bit [7:0] g,
                            input bit [7:0] b, input bit [7:0] a);
    s_tvalid <= 1'b1;
    s_tdata <= {a, b, g, r};
    s_tuser <= sof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
  endtask

  // Let the pipeline empty so registers can change safely. The first edge
  // makes sure the last accepted pixel has been noted by the scoreboard.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic bit [7:0] pick_alpha();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1, 2: return 8'hFF;
      3: return $urandom_range(0, 1) ? 8'h01 : 8'hFE;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly inside the display so pixels land and get blended repeatedly
  function automatic bit [15:0] pick_offset();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'($urandom_range(240, 255));
      2: return 16'($urandom);
      3: return 16'hFFFF;
      default: return 16'($urandom_range(0, 230));
    endcase
  endfunction

  function automatic bit [15:0] pick_width();
    case ($urandom_range(0, 7))
      0: return 16'd1;
      1: return 16'($urandom_range(2, 64));
      2: return 16'(MAX_WIDTH);
      3: return 16'd0;
      4: return 16'($urandom_range(MAX_WIDTH + 1, 2**WIDTH_W - 1));
      default: return 16'($urandom_range(1, 16));
    endcase
  endfunction

  // Short images with random content under one register setting. Most start
  // cleanly with start_of_image; a few have a stray or missing marker.
  task automatic run_images(input bit [15:0] ox, input bit [15:0] oy, input bit [15:0] w,
                            input int unsigned budget);
    int unsigned sent;
    int unsigned len;
    bit          sof;
    program_regs(ox, oy, w);
    sent = 0;
    while (sent < budget) begin
      len = $urandom_range(1, 48);
      for (int i = 0; i < len; i++) begin
        sof = (i == 0);
        if ($urandom_range(0, 29) == 0) sof = ~sof;
        send_pixel(sof, 8'($urandom), 8'($urandom), 8'($urandom), pick_alpha());
      end
      sent += len;
    end
    settle();
    random_total += sent;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Top-left corner, four-wide image: opaque, transparent and partial alpha
    // onto a cleared store, then a second pass blending over what was written.
    program_regs(16'd0, 16'd0, 16'd4);
    send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_pixel(1'b0, 8'h12, 8'h34, 8'h56, 8'h00);
    send_pixel(1'b0, 8'hFF, 8'h00, 8'h80, 8'h80);
    send_pixel(1'b0, 8'hA5, 8'h5A, 8'hC3, 8'h01);
    send_pixel(1'b0, 8'h3C, 8'hE7, 8'h81, 8'hFE);
    send_pixel(1'b0, 8'h08, 8'h04, 8'h08, 8'hFF);
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_pixel(1'b1, 8'h00, 8'hFF, 8'h00, 8'h80);
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h01);
    send_pixel(1'b0, 8'h7F, 8'h80, 8'h7F, 8'hFE);
    send_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    settle();

    // Bottom-right corner: the image runs off the right and bottom edges,
    // then a fresh start clears the sticky flag and re-blends the corner.
    program_regs(16'd254, 16'd255, 16'd3);
    send_pixel(1'b1, 8'hF0, 8'h0F, 8'hAA, 8'hFF);
    send_pixel(1'b0, 8'h55, 8'hAA, 8'h55, 8'h80);
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(1'b1, 8'h00, 8'h80, 8'hFF, 8'h40);
    settle();

    // Largest offsets and a width beyond the maximum: coordinates past 16 bits
    program_regs(16'hFFFF, 16'hFFFF, 16'h1FFF);
    send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'h80);
    settle();

    // Width extremes first, then random settings
    run_images(16'd0, 16'd0, 16'd0, 120);
    run_images(pick_offset(), 16'd0, 16'(MAX_WIDTH), 80);
    run_images(16'd0, pick_offset(), 16'd1, 60);
    while (random_total < RANDOM_ITEMS)
      run_images(pick_offset(), pick_offset(), pick_width(), $urandom_range(30, 90));

    repeat (16) @(posedge clk);
    if (ledger.faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
